[hdl/lrfic_pkg.sv]
// ----------------------------------------------------------------------------
// lrfic_pkg
// Types, widths and constants shared by the lidar return filter files.
// ----------------------------------------------------------------------------
`default_nettype none

package lrfic_pkg;

   // default sizes of the calibration store
   localparam int LaserCountDef     = 32;
   localparam int DistanceBinsDef   = 10;
   localparam int IntensityLevels   = 256;
   localparam int MaxBinBounds      = 15;

   // field widths
   localparam int LaserW     = 5;
   localparam int CoordW     = 18;
   localparam int RangeW     = 18;
   localparam int IntensityW = 8;
   localparam int BinW       = 4;
   localparam int CsrIndexW  = 3;
   localparam int CsrDataW   = 18;
   localparam int BoxW       = 16;
   localparam int ModeW      = 2;
   localparam int SquareW    = 35;
   localparam int DistSqW    = 36;

   // range window, millimetres
   localparam logic [RangeW-1:0] RangeMinMm = RangeW'(1000);
   localparam logic [RangeW-1:0] RangeMaxMm = RangeW'(70000);

   // smallest squared floor distance (mm^2) that reaches bin k+1
   localparam logic [DistSqW-1:0] BinBoundSq [MaxBinBounds] = '{
      36'd13720798,    36'd18028782,    36'd25318461,    36'd38081620,
      36'd61199242,    36'd104414512,   36'd187459795,   36'd350731011,
      36'd677578083,   36'd1340949593,  36'd2701142726,  36'd5510857862,
      36'd11345652095, 36'd23507990799, 36'd48926599476
   };

   typedef enum logic [CsrIndexW-1:0] {
      CSR_CEILING    = 3'd0,
      CSR_FLOOR      = 3'd1,
      CSR_BOX_REAR   = 3'd2,
      CSR_BOX_FRONT  = 3'd3,
      CSR_BOX_HALF_W = 3'd4,
      CSR_MODE       = 3'd5
   } csr_index_type;

   typedef enum logic [ModeW-1:0] {
      MODE_RAW    = 2'd0,
      MODE_DOUBLE = 2'd1,
      MODE_QUAD   = 2'd2
   } mode_type;

   localparam logic FUNC_POINT = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // brighten a calibrated value by mode, saturating at full scale
   function automatic logic [IntensityW-1:0] brighten(
      input logic [IntensityW-1:0] val,
      input logic [ModeW-1:0]      mode
   );
      logic [IntensityW-1:0] res;
      res = val;
      if (mode == MODE_DOUBLE) begin
         res = val[7] ? 8'hFF : {val[6:0], 1'b0};
      end else if (mode == MODE_QUAD) begin
         res = (val[7:6] != 2'b00) ? 8'hFF : {val[5:0], 2'b00};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[hdl/lrfic_if.sv]
// ----------------------------------------------------------------------------
// lrfic channel interfaces
// Return/write request, result and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrfic_req_if import lrfic_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic [LaserW-1:0]            laser_num;
   logic [RangeW-1:0]            range_mm;
   logic signed [CoordW-1:0]     sensor_x;
   logic signed [CoordW-1:0]     sensor_y;
   logic signed [CoordW-1:0]     sensor_z;
   logic signed [CoordW-1:0]     car_x;
   logic signed [CoordW-1:0]     car_y;
   logic [IntensityW-1:0]        raw_level;
   logic [BinW-1:0]              write_bin;
   logic [IntensityW-1:0]        write_value;

   modport source (output valid, func, laser_num, range_mm, sensor_x, sensor_y, sensor_z,
                   car_x, car_y, raw_level, write_bin, write_value, input ready);
   modport sink   (input valid, func, laser_num, range_mm, sensor_x, sensor_y, sensor_z,
                   car_x, car_y, raw_level, write_bin, write_value, output ready);
endinterface

interface lrfic_rsp_if import lrfic_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  point_valid;
   logic [IntensityW-1:0] out_intensity;
   logic [BinW-1:0]       distance_bin;

   modport source (output valid, point_valid, out_intensity, distance_bin, input ready);
   modport sink   (input valid, point_valid, out_intensity, distance_bin, output ready);
endinterface

interface lrfic_csr_if import lrfic_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CsrIndexW-1:0] index;
   logic [CsrDataW-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/lrfic_table.sv]
// ----------------------------------------------------------------------------
// lrfic_table
// Calibration store: single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrfic_table import lrfic_pkg::*; #(
   parameter int DEPTH  = LaserCountDef * DistanceBinsDef * IntensityLevels,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic                  we,
   input  wire logic [ADDR_W-1:0]     addr,
   input  wire logic [IntensityW-1:0] wdata,
   output logic      [IntensityW-1:0] rdata_ff
);

   logic [IntensityW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem[addr] <= wdata;
      end
   end

   // hold the last read word while idle or writing
   always_ff @(posedge clock) begin
      if (en && !we) begin
         rdata_ff <= mem[addr];
      end
   end

endmodule

`default_nettype wire

[hdl/lidar_return_filter_intensity_calib_core.sv]
// ----------------------------------------------------------------------------
// lidar_return_filter_intensity_calib_core
// Filters lidar returns by range, car box and height, bins the floor distance
// and looks up a calibrated intensity per laser, bin and raw intensity.
// ----------------------------------------------------------------------------
//  channel  | direction | word
//  req_ch   | in        | return to filter, or calibration table write
//  rsp_ch   | out       | point_valid, out_intensity, distance_bin
//  csr_ch   | in        | register index and data, always ready
//
//  One word per cycle sustained while rsp_ch is ready; each word passes in order
//  through filter and squares, then bin search and table access, then brightening.
//  The single table port is used at most once per word, by a read or by a write.
//  Every stage holds only when the stage after it is full and stalled.
//  Reset sets the registers to defaults and clears valid flags; the table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_return_filter_intensity_calib_core import lrfic_pkg::*; #(
   parameter int LASER_COUNT   = LaserCountDef,
   parameter int DISTANCE_BINS = DistanceBinsDef
) (
   input wire logic  clock,
   input wire logic  reset,
   lrfic_req_if.sink   req_ch,
   lrfic_rsp_if.source rsp_ch,
   lrfic_csr_if.sink   csr_ch
);

   localparam int Depth = LASER_COUNT * DISTANCE_BINS * IntensityLevels;
   localparam int AddrW = $clog2(Depth);
   localparam int RowW  = AddrW - IntensityW;

   // registers
   logic signed [CoordW-1:0] ceiling_ff;
   logic signed [CoordW-1:0] floor_ff;
   logic [BoxW-1:0]          box_rear_ff;
   logic [BoxW-1:0]          box_front_ff;
   logic [BoxW-1:0]          box_half_ff;
   logic [ModeW-1:0]         mode_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff   <= CoordW'(131071);
         floor_ff     <= -CoordW'(131072);
         box_rear_ff  <= '0;
         box_front_ff <= '0;
         box_half_ff  <= '0;
         mode_ff      <= MODE_RAW;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_CEILING:    ceiling_ff   <= csr_ch.data;
            CSR_FLOOR:      floor_ff     <= csr_ch.data;
            CSR_BOX_REAR:   box_rear_ff  <= csr_ch.data[BoxW-1:0];
            CSR_BOX_FRONT:  box_front_ff <= csr_ch.data[BoxW-1:0];
            CSR_BOX_HALF_W: box_half_ff  <= csr_ch.data[BoxW-1:0];
            CSR_MODE:       mode_ff      <= csr_ch.data[ModeW-1:0];
            default: ;
         endcase
      end
   end

   // stage enables
   logic s1_vld_ff, s2_vld_ff, rsp_vld_ff;
   logic s1_en, s2_en, rsp_en;

   assign rsp_en       = !rsp_vld_ff || rsp_ch.ready;
   assign s2_en        = !s2_vld_ff || rsp_en;
   assign s1_en        = !s1_vld_ff || s2_en;
   assign req_ch.ready = s1_en;

   // stage 0: filter tests and squares
   logic                  keep_in, act_in;
   logic signed [CoordW:0] cx_w, cy_w, rear_n, front_p, half_p, half_n;
   logic                  in_box, laser_ok;
   logic signed [2*CoordW-1:0] sqx_full, sqy_full;

   always_comb begin
      cx_w     = {req_ch.car_x[CoordW-1], req_ch.car_x};
      cy_w     = {req_ch.car_y[CoordW-1], req_ch.car_y};
      front_p  = signed'({3'b000, box_front_ff});
      half_p   = signed'({3'b000, box_half_ff});
      rear_n   = -signed'({3'b000, box_rear_ff});
      half_n   = -half_p;
      in_box   = (cx_w > rear_n) && (cx_w < front_p) && (cy_w > half_n) && (cy_w < half_p);
      laser_ok = ({3'b000, req_ch.laser_num} < (LaserW+3)'(LASER_COUNT));
      keep_in  = (req_ch.range_mm >= RangeMinMm) && (req_ch.range_mm < RangeMaxMm)
                 && !in_box && !(req_ch.sensor_z > ceiling_ff)
                 && !(req_ch.sensor_z < floor_ff) && laser_ok;
      // table access needed: kept point reads, valid write stores
      act_in   = (req_ch.func == FUNC_WRITE)
                 ? (laser_ok && ({1'b0, req_ch.write_bin} < (BinW+1)'(DISTANCE_BINS)))
                 : keep_in;
      sqx_full = req_ch.sensor_x * req_ch.sensor_x;
      sqy_full = req_ch.sensor_y * req_ch.sensor_y;
   end

   logic                  s1_wr_ff, s1_keep_ff, s1_act_ff;
   logic [LaserW-1:0]     s1_laser_ff;
   logic [IntensityW-1:0] s1_raw_ff, s1_wval_ff;
   logic [BinW-1:0]       s1_wbin_ff;
   logic [SquareW-1:0]    s1_sqx_ff, s1_sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_en) begin
         s1_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_wr_ff    <= (req_ch.func == FUNC_WRITE);
         s1_keep_ff  <= keep_in && (req_ch.func == FUNC_POINT);
         s1_act_ff   <= act_in;
         s1_laser_ff <= req_ch.laser_num;
         s1_raw_ff   <= req_ch.raw_level;
         s1_wval_ff  <= req_ch.write_value;
         s1_wbin_ff  <= req_ch.write_bin;
         s1_sqx_ff   <= sqx_full[SquareW-1:0];
         s1_sqy_ff   <= sqy_full[SquareW-1:0];
      end
   end

   // stage 1: bin search and table access
   logic [DistSqW-1:0]      dist_sq;
   logic [MaxBinBounds-1:0] bound_hit;
   logic [BinW-1:0]         bin_in, row_bin;
   logic [RowW-1:0]         row;
   logic [AddrW-1:0]        tbl_addr;

   always_comb begin
      dist_sq = {1'b0, s1_sqx_ff} + {1'b0, s1_sqy_ff};
      for (int k = 0; k < MaxBinBounds; k++) begin
         bound_hit[k] = (k < DISTANCE_BINS - 1) && (dist_sq >= BinBoundSq[k]);
      end
      bin_in   = BinW'($countones(bound_hit));
      row_bin  = s1_wr_ff ? s1_wbin_ff : bin_in;
      row      = RowW'(s1_laser_ff) * RowW'(DISTANCE_BINS) + RowW'(row_bin);
      tbl_addr = {row, s1_raw_ff};
   end

   logic                  tbl_en;
   logic [IntensityW-1:0] tbl_rdata;

   assign tbl_en = s2_en && s1_vld_ff && s1_act_ff;

   lrfic_table #(
      .DEPTH  (Depth),
      .ADDR_W (AddrW)
   ) u_table (
      .clock    (clock),
      .en       (tbl_en),
      .we       (s1_wr_ff),
      .addr     (tbl_addr),
      .wdata    (s1_wval_ff),
      .rdata_ff (tbl_rdata)
   );

   logic            s2_keep_ff;
   logic [BinW-1:0] s2_bin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (s2_en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_keep_ff <= s1_keep_ff;
         s2_bin_ff  <= bin_in;
      end
   end

   // stage 2: brighten into the result register
   logic                  rsp_point_ff;
   logic [IntensityW-1:0] rsp_int_ff;
   logic [BinW-1:0]       rsp_bin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_en) begin
         rsp_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_en) begin
         rsp_point_ff <= s2_keep_ff;
         rsp_int_ff   <= s2_keep_ff ? brighten(tbl_rdata, mode_ff) : '0;
         rsp_bin_ff   <= s2_keep_ff ? s2_bin_ff : '0;
      end
   end

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.point_valid   = rsp_point_ff;
   assign rsp_ch.out_intensity = rsp_int_ff;
   assign rsp_ch.distance_bin  = rsp_bin_ff;

endmodule

`default_nettype wire
